// ===== design/rms_flickermeter_filter_chain_top_macros.svh =====
// Assertion macros used by the flicker filter chain core.
`ifndef RMS_FLICKERMETER_FILTER_CHAIN_TOP_MACROS_SVH
`define RMS_FLICKERMETER_FILTER_CHAIN_TOP_MACROS_SVH

// Checks that the condition post holds in the same cycle as pre.
`define FLK_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Checks that the condition post holds in the cycle after pre.
`define FLK_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/flk_pkg.sv =====
// Shared types, constants and build-time helper functions of the flicker filter chain.
package flk_pkg;

    localparam int unsigned SPS_DEFAULT          = 120;
    localparam int unsigned SAMPLE_WIDTH_DEFAULT = 16;
    localparam int unsigned IN_W                 = 16;
    localparam int unsigned DATA_W               = 32;
    localparam int unsigned ACC_W                = 36;
    localparam int unsigned PROD_W               = 64;
    localparam int unsigned STEP_W               = 5;
    localparam int unsigned CFG_IDX_W            = 1;
    localparam int unsigned SCALE_BITS           = 11;

    localparam logic [STEP_W-1:0] STEP_LAST = 5'd17;
    localparam logic [1:0]        WARM_DONE = 2'd2;

    localparam logic [DATA_W-1:0] RECIP_RESET = 32'h4000_0000;
    localparam logic [DATA_W-1:0] SCALE_MUL   = 32'd1000000000;
    localparam logic [PROD_W-1:0] SCALE_BIAS  = 64'd164480;
    localparam int unsigned       DIV_D       = 328960;
    localparam int unsigned       DIV_W       = $clog2(DIV_D);
    localparam logic [PROD_W-1:0] SCALE_LIMIT = 64'(DIV_D) << DATA_W;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef logic signed [127:0] t_wide;

    localparam t_wide PI_Q30    = 128'sd3373259426;
    localparam t_wide OMEGA_DIV = 128'sd1000000 <<< (30 - SCALE_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        K_NORM,
        K_MAC,
        K_SQ,
        K_SCALE
    } t_kind;

    typedef enum logic [2:0] {
        STG_NONE,
        STG_HP,
        STG_BP,
        STG_WT,
        STG_LP
    } t_stage;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_USE_50HZ   = 1'b0,
        REG_BASE_RECIP = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] num;
    } t_div_req;

    function automatic t_wide wabs(input t_wide v);
        return (v < 0) ? -v : v;
    endfunction

    // Angular frequency 2*pi*f in Q.11, f given in micro-hertz.
    function automatic t_wide omega(input t_wide f);
        return (2 * PI_Q30 * f + OMEGA_DIV / 2) / OMEGA_DIV;
    endfunction

    // Rounds a ratio to Q2.30 given q = floor(|n| * 2^31 / d), saturating.
    function automatic logic signed [DATA_W-1:0] qfix(input t_wide n, input t_wide d,
                                                      input t_wide q);
        t_wide r;
        r = (q + 1) >>> 1;
        if (d == 0) return '0;
        if (wabs(n) >= 2 * d) return (n < 0) ? Q_MIN : Q_MAX;
        if (n < 0) return DATA_W'(-r);
        if (r > 128'sd2147483647) return Q_MAX;
        return DATA_W'(r);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > 36'sd2147483647) return Q_MAX;
        if (v < -36'sd2147483648) return Q_MIN;
        return v[DATA_W-1:0];
    endfunction

endpackage

// ===== design/flk_mul.sv =====
// Bit-serial unsigned 32 by 32 multiplier, one multiplier bit per cycle.
module flk_mul
    import flk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mul_req          i_req,
    output logic              o_done,
    output logic [PROD_W-1:0] o_prod
);

    localparam logic [4:0] CNT_LAST = 5'(DATA_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    logic [PROD_W-1:0] r_acc;
    logic [DATA_W-1:0] r_mcand;
    logic [DATA_W:0]   sum;

    assign sum = {1'b0, r_acc[PROD_W-1:DATA_W]} + (r_acc[0] ? {1'b0, r_mcand} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_acc   <= {{DATA_W{1'b0}}, i_req.b};
                r_mcand <= i_req.a;
            end else if (r_busy) begin
                r_acc <= {sum, r_acc[DATA_W-1:1]};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== design/flk_div.sv =====
// Bit-serial restoring divider by the fixed output scale divisor, one quotient bit per cycle.
module flk_div
    import flk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quot
);

    localparam logic [DIV_W:0] DIVISOR  = (DIV_W + 1)'(DIV_D);
    localparam logic [4:0]     CNT_LAST = 5'(DATA_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [DATA_W-1:0] r_q;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              ge;

    assign trial = {r_rem, r_q[DATA_W-1]};
    assign ge    = trial >= DIVISOR;
    assign diff  = trial - DIVISOR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_req.num[DATA_W+DIV_W-1:DATA_W];
                r_q    <= i_req.num[DATA_W-1:0];
            end else if (r_busy) begin
                r_rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                r_q   <= {r_q[DATA_W-2:0], ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== design/flk_core.sv =====
// Sequencer, filter state and accumulator of the flicker weighting chain.
`include "rms_flickermeter_filter_chain_top_macros.svh"
module flk_core
    import flk_pkg::*;
#(
    parameter int unsigned SAMPLES_PER_SECOND = SPS_DEFAULT,
    parameter int unsigned SAMPLE_WIDTH       = SAMPLE_WIDTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [IN_W-1:0]   i_sample,
    input  logic              i_restart,
    input  logic              i_use_50hz_set,
    input  logic [DATA_W-1:0] i_base_voltage_recip,
    input  logic              i_out_free,
    output logic              o_idle,
    output logic              o_done,
    output logic [DATA_W-1:0] o_result
);

    // Common filter constants.
    localparam t_wide FS   = t_wide'(SAMPLES_PER_SECOND);
    localparam t_wide FSS  = FS <<< SCALE_BITS;
    localparam t_wide Q4   = 4 * FSS * FSS;
    localparam t_wide HP_V = (20 * FS) <<< 30;
    localparam t_wide HP_D = HP_V + PI_Q30;
    localparam t_wide HA_N = PI_Q30 - HP_V;
    localparam t_wide LG_N = 128'sd5;
    localparam t_wide LP_D = 5 + 3 * FS;
    localparam t_wide LA_N = 5 - 3 * FS;

    localparam logic signed [31:0] C_HG = qfix(HP_V, HP_D, (wabs(HP_V) <<< 31) / HP_D);
    localparam logic signed [31:0] C_HA = qfix(HA_N, HP_D, (wabs(HA_N) <<< 31) / HP_D);
    localparam logic signed [31:0] C_LG = qfix(LG_N, LP_D, (wabs(LG_N) <<< 31) / LP_D);
    localparam logic signed [31:0] C_LA = qfix(LA_N, LP_D, (wabs(LA_N) <<< 31) / LP_D);

    // 60 Hz lamp set.
    localparam t_wide S6_KN  = 128'sd16357;
    localparam t_wide S6_KD  = 128'sd7830;
    localparam t_wide S6_LAM = omega(128'sd4167375);
    localparam t_wide S6_W1  = omega(128'sd9077169);
    localparam t_wide S6_W2  = omega(128'sd2939902);
    localparam t_wide S6_W3  = omega(128'sd1394468);
    localparam t_wide S6_W4  = omega(128'sd17315120);
    localparam t_wide S6_A0  = S6_W1 * S6_W1 + 4 * S6_LAM * FSS + Q4;
    localparam t_wide S6_BN  = 2 * S6_KN * S6_W1 * FSS;
    localparam t_wide S6_BD  = S6_KD * S6_A0;
    localparam t_wide S6_A1N = 2 * S6_W1 * S6_W1 - 8 * FSS * FSS;
    localparam t_wide S6_A2N = S6_W1 * S6_W1 - 4 * S6_LAM * FSS + Q4;
    localparam t_wide S6_PR  = S6_W3 * S6_W4;
    localparam t_wide S6_SM  = S6_W3 + S6_W4;
    localparam t_wide S6_D0  = S6_PR + 2 * FSS * S6_SM + Q4;
    localparam t_wide S6_WD  = S6_W2 * S6_D0;
    localparam t_wide S6_C0N = S6_PR * (S6_W2 + 2 * FSS);
    localparam t_wide S6_C1N = S6_PR * 2 * S6_W2;
    localparam t_wide S6_C2N = S6_PR * (S6_W2 - 2 * FSS);
    localparam t_wide S6_E1N = 2 * S6_PR - 8 * FSS * FSS;
    localparam t_wide S6_E2N = S6_PR - 2 * FSS * S6_SM + Q4;

    localparam logic signed [31:0] S6_B0 = qfix(S6_BN, S6_BD, (wabs(S6_BN) <<< 31) / S6_BD);
    localparam logic signed [31:0] S6_A1 = qfix(S6_A1N, S6_A0, (wabs(S6_A1N) <<< 31) / S6_A0);
    localparam logic signed [31:0] S6_A2 = qfix(S6_A2N, S6_A0, (wabs(S6_A2N) <<< 31) / S6_A0);
    localparam logic signed [31:0] S6_C0 = qfix(S6_C0N, S6_WD, (wabs(S6_C0N) <<< 31) / S6_WD);
    localparam logic signed [31:0] S6_C1 = qfix(S6_C1N, S6_WD, (wabs(S6_C1N) <<< 31) / S6_WD);
    localparam logic signed [31:0] S6_C2 = qfix(S6_C2N, S6_WD, (wabs(S6_C2N) <<< 31) / S6_WD);
    localparam logic signed [31:0] S6_E1 = qfix(S6_E1N, S6_D0, (wabs(S6_E1N) <<< 31) / S6_D0);
    localparam logic signed [31:0] S6_E2 = qfix(S6_E2N, S6_D0, (wabs(S6_E2N) <<< 31) / S6_D0);

    // 50 Hz lamp set.
    localparam t_wide S5_KN  = 128'sd174802;
    localparam t_wide S5_KD  = 128'sd100000;
    localparam t_wide S5_LAM = omega(128'sd4059810);
    localparam t_wide S5_W1  = omega(128'sd9154940);
    localparam t_wide S5_W2  = omega(128'sd2279790);
    localparam t_wide S5_W3  = omega(128'sd1225350);
    localparam t_wide S5_W4  = omega(128'sd21900000);
    localparam t_wide S5_A0  = S5_W1 * S5_W1 + 4 * S5_LAM * FSS + Q4;
    localparam t_wide S5_BN  = 2 * S5_KN * S5_W1 * FSS;
    localparam t_wide S5_BD  = S5_KD * S5_A0;
    localparam t_wide S5_A1N = 2 * S5_W1 * S5_W1 - 8 * FSS * FSS;
    localparam t_wide S5_A2N = S5_W1 * S5_W1 - 4 * S5_LAM * FSS + Q4;
    localparam t_wide S5_PR  = S5_W3 * S5_W4;
    localparam t_wide S5_SM  = S5_W3 + S5_W4;
    localparam t_wide S5_D0  = S5_PR + 2 * FSS * S5_SM + Q4;
    localparam t_wide S5_WD  = S5_W2 * S5_D0;
    localparam t_wide S5_C0N = S5_PR * (S5_W2 + 2 * FSS);
    localparam t_wide S5_C1N = S5_PR * 2 * S5_W2;
    localparam t_wide S5_C2N = S5_PR * (S5_W2 - 2 * FSS);
    localparam t_wide S5_E1N = 2 * S5_PR - 8 * FSS * FSS;
    localparam t_wide S5_E2N = S5_PR - 2 * FSS * S5_SM + Q4;

    localparam logic signed [31:0] S5_B0 = qfix(S5_BN, S5_BD, (wabs(S5_BN) <<< 31) / S5_BD);
    localparam logic signed [31:0] S5_A1 = qfix(S5_A1N, S5_A0, (wabs(S5_A1N) <<< 31) / S5_A0);
    localparam logic signed [31:0] S5_A2 = qfix(S5_A2N, S5_A0, (wabs(S5_A2N) <<< 31) / S5_A0);
    localparam logic signed [31:0] S5_C0 = qfix(S5_C0N, S5_WD, (wabs(S5_C0N) <<< 31) / S5_WD);
    localparam logic signed [31:0] S5_C1 = qfix(S5_C1N, S5_WD, (wabs(S5_C1N) <<< 31) / S5_WD);
    localparam logic signed [31:0] S5_C2 = qfix(S5_C2N, S5_WD, (wabs(S5_C2N) <<< 31) / S5_WD);
    localparam logic signed [31:0] S5_E1 = qfix(S5_E1N, S5_D0, (wabs(S5_E1N) <<< 31) / S5_D0);
    localparam logic signed [31:0] S5_E2 = qfix(S5_E2N, S5_D0, (wabs(S5_E2N) <<< 31) / S5_D0);

    t_state r_state, n_state;

    logic [STEP_W-1:0]       r_step;
    logic [SAMPLE_WIDTH-1:0] r_smp;
    logic signed [31:0]      r_x, r_sq;
    logic signed [31:0]      r_hp_in, r_hp_out;
    logic signed [31:0]      r_bp_in0, r_bp_in1, r_bp_out0, r_bp_out1;
    logic signed [31:0]      r_wt_in0, r_wt_in1, r_wt_out0, r_wt_out1;
    logic signed [31:0]      r_lp_in, r_lp_out;
    logic [1:0]              r_warm;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_neg;
    logic [DATA_W-1:0]       r_result;

    logic [DATA_W-1:0]       samp_ext;
    t_kind                   kind;
    t_stage                  stage;
    logic [DATA_W-1:0]       op_a, op_b;
    logic                    first, sub;
    logic                    sgn_a, sgn_b;
    logic [DATA_W-1:0]       mag_a, mag_b;
    logic signed [31:0]      k_b0, k_a1, k_a2, k_c0, k_c1, k_c2, k_e1, k_e2;

    t_mul_req                mul_req;
    t_div_req                div_req;
    logic                    mul_done, div_done;
    logic [PROD_W-1:0]       prod;
    logic [DATA_W-1:0]       div_quot;

    logic [PROD_W-1:0]       rnd_norm, rnd_mac, rnd_sq, scale_num;
    logic [DATA_W:0]         mac_mag;
    logic signed [ACC_W-1:0] term, acc_new;
    logic signed [31:0]      stage_val, x_sat, sq_sat;
    logic                    lp_pos, scale_sat;

    assign samp_ext = DATA_W'(i_sample);

    assign k_b0 = i_use_50hz_set ? S5_B0 : S6_B0;
    assign k_a1 = i_use_50hz_set ? S5_A1 : S6_A1;
    assign k_a2 = i_use_50hz_set ? S5_A2 : S6_A2;
    assign k_c0 = i_use_50hz_set ? S5_C0 : S6_C0;
    assign k_c1 = i_use_50hz_set ? S5_C1 : S6_C1;
    assign k_c2 = i_use_50hz_set ? S5_C2 : S6_C2;
    assign k_e1 = i_use_50hz_set ? S5_E1 : S6_E1;
    assign k_e2 = i_use_50hz_set ? S5_E2 : S6_E2;

    // Microcode: one multiplication per step, stage results written on the last term.
    always_comb begin
        kind  = K_MAC;
        stage = STG_NONE;
        op_a  = '0;
        op_b  = '0;
        first = 1'b0;
        sub   = 1'b0;
        case (r_step)
            5'd0:  begin kind = K_NORM; op_a = i_base_voltage_recip; op_b = DATA_W'(r_smp); end
            5'd1:  begin op_a = C_HG; op_b = r_x;       first = 1'b1; end
            5'd2:  begin op_a = C_HG; op_b = r_hp_in;   sub = 1'b1; end
            5'd3:  begin op_a = C_HA; op_b = r_hp_out;  sub = 1'b1; stage = STG_HP; end
            5'd4:  begin op_a = k_b0; op_b = r_hp_out;  first = 1'b1; end
            5'd5:  begin op_a = k_b0; op_b = r_bp_in1;  sub = 1'b1; end
            5'd6:  begin op_a = k_a1; op_b = r_bp_out0; sub = 1'b1; end
            5'd7:  begin op_a = k_a2; op_b = r_bp_out1; sub = 1'b1; stage = STG_BP; end
            5'd8:  begin op_a = k_c0; op_b = r_bp_out0; first = 1'b1; end
            5'd9:  begin op_a = k_c1; op_b = r_wt_in0; end
            5'd10: begin op_a = k_c2; op_b = r_wt_in1; end
            5'd11: begin op_a = k_e1; op_b = r_wt_out0; sub = 1'b1; end
            5'd12: begin op_a = k_e2; op_b = r_wt_out1; sub = 1'b1; stage = STG_WT; end
            5'd13: begin kind = K_SQ; op_a = r_wt_out0; op_b = r_wt_out0; end
            5'd14: begin op_a = C_LG; op_b = r_sq;      first = 1'b1; end
            5'd15: begin op_a = C_LG; op_b = r_lp_in; end
            5'd16: begin op_a = C_LA; op_b = r_lp_out;  sub = 1'b1; stage = STG_LP; end
            5'd17: begin kind = K_SCALE; op_a = SCALE_MUL; op_b = r_lp_out; end
            default: begin kind = K_NORM; end
        endcase
    end

    assign sgn_a = (kind != K_NORM) && op_a[DATA_W-1];
    assign sgn_b = (kind != K_NORM) && op_b[DATA_W-1];
    assign mag_a = sgn_a ? (~op_a + 32'd1) : op_a;
    assign mag_b = sgn_b ? (~op_b + 32'd1) : op_b;

    assign rnd_norm  = prod + 64'd32;
    assign rnd_mac   = prod + (64'd1 << 29);
    assign rnd_sq    = prod + (64'd1 << 23);
    assign scale_num = prod + SCALE_BIAS;

    assign mac_mag   = rnd_mac[62:30];
    assign term      = r_neg ? -$signed(ACC_W'(mac_mag)) : $signed(ACC_W'(mac_mag));
    assign acc_new   = (first ? '0 : r_acc) + (sub ? -term : term);
    assign stage_val = sat32(acc_new);

    assign x_sat  = (|rnd_norm[63:37]) ? Q_MAX : {1'b0, rnd_norm[36:6]};
    assign sq_sat = (|rnd_sq[63:55]) ? Q_MAX : {1'b0, rnd_sq[54:24]};

    assign lp_pos    = !r_lp_out[31] && (r_lp_out != '0);
    assign scale_sat = scale_num >= SCALE_LIMIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        mul_req.start = 1'b0;
        mul_req.a     = mag_a;
        mul_req.b     = mag_b;
        div_req.start = 1'b0;
        div_req.num   = scale_num;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                mul_req.start = 1'b1;
                n_state       = ST_MUL;
            end
            ST_MUL: begin
                if (mul_done) begin
                    if (r_step == STEP_LAST) begin
                        if (!lp_pos || scale_sat) begin
                            n_state = ST_DONE;
                        end else begin
                            div_req.start = 1'b1;
                            n_state       = ST_DIV;
                        end
                    end else begin
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= '0;
            r_warm    <= '0;
            r_hp_in   <= '0;
            r_hp_out  <= '0;
            r_bp_in0  <= '0;
            r_bp_in1  <= '0;
            r_bp_out0 <= '0;
            r_bp_out1 <= '0;
            r_wt_in0  <= '0;
            r_wt_in1  <= '0;
            r_wt_out0 <= '0;
            r_wt_out1 <= '0;
            r_lp_in   <= '0;
            r_lp_out  <= '0;
        end else begin
            if (r_state == ST_IDLE && i_start) begin
                r_step <= '0;
                r_smp  <= samp_ext[SAMPLE_WIDTH-1:0];
                if (i_restart) begin
                    r_warm    <= '0;
                    r_hp_in   <= '0;
                    r_hp_out  <= '0;
                    r_bp_in0  <= '0;
                    r_bp_in1  <= '0;
                    r_bp_out0 <= '0;
                    r_bp_out1 <= '0;
                    r_wt_in0  <= '0;
                    r_wt_in1  <= '0;
                    r_wt_out0 <= '0;
                    r_wt_out1 <= '0;
                    r_lp_in   <= '0;
                    r_lp_out  <= '0;
                end
            end
            if (r_state == ST_ISSUE) begin
                r_neg <= sgn_a ^ sgn_b;
            end
            if (r_state == ST_MUL && mul_done) begin
                if (r_step != STEP_LAST) r_step <= r_step + 5'd1;
                case (kind)
                    K_NORM:  r_x <= x_sat;
                    K_SQ:    r_sq <= sq_sat;
                    K_SCALE: r_result <= lp_pos ? '1 : '0;
                    K_MAC: begin
                        r_acc <= acc_new;
                        case (stage)
                            STG_HP: begin
                                r_hp_in  <= r_x;
                                r_hp_out <= (r_warm == 2'd0) ? '0 : stage_val;
                            end
                            STG_BP: begin
                                r_bp_in1  <= r_bp_in0;
                                r_bp_in0  <= r_hp_out;
                                r_bp_out1 <= r_bp_out0;
                                r_bp_out0 <= (r_warm != WARM_DONE) ? '0 : stage_val;
                            end
                            STG_WT: begin
                                r_wt_in1  <= r_wt_in0;
                                r_wt_in0  <= r_bp_out0;
                                r_wt_out1 <= r_wt_out0;
                                r_wt_out0 <= (r_warm != WARM_DONE) ? '0 : stage_val;
                            end
                            STG_LP: begin
                                r_lp_in  <= r_sq;
                                r_lp_out <= (r_warm == 2'd0) ? '0 : stage_val;
                                if (r_warm != WARM_DONE) r_warm <= r_warm + 2'd1;
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            if (r_state == ST_DIV && div_done) begin
                r_result <= div_quot;
            end
        end
    end

    flk_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    flk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_idle   = (r_state == ST_IDLE);
    assign o_done   = (r_state == ST_DONE);
    assign o_result = r_result;

    `FLK_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_start, r_state == ST_IDLE, "start outside idle")
    `FLK_ASSERT_NXT(a_issue_mul, i_clk, i_rst_n, r_state == ST_ISSUE, r_state == ST_MUL, "issue did not start a multiply")
    `FLK_ASSERT_IMP(a_step_range, i_clk, i_rst_n, r_state != ST_IDLE, r_step <= STEP_LAST, "step past end of program")
    `FLK_ASSERT_IMP(a_warm_range, i_clk, i_rst_n, 1'b1, r_warm <= WARM_DONE, "warm-up count out of range")
    `FLK_ASSERT_NXT(a_done_release, i_clk, i_rst_n, r_state == ST_DONE && i_out_free, r_state == ST_IDLE, "result not released")

endmodule

// ===== design/rms_flickermeter_filter_chain_top.sv =====
// Top level of the instantaneous flicker filter chain with stream ports and configuration.
//
// Each accepted word is one RMS sample; one flicker word comes out per sample. All
// multiplications run through one bit-serial 32 by 32 multiplier: a sample takes 18
// multiplications, each an issue, a shift-add pass and a result, followed by the
// bit-serial output divider when the result is neither zero nor saturated. A new
// sample is accepted as soon as the previous one has moved into the output register.
module rms_flickermeter_filter_chain_top
    import flk_pkg::*;
#(
    parameter int unsigned SAMPLES_PER_SECOND = SPS_DEFAULT,
    parameter int unsigned SAMPLE_WIDTH       = SAMPLE_WIDTH_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,   // [15:0] rms_level
    input  logic                 s_axis_tuser,   // [0] restart
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DATA_W-1:0]    m_axis_tdata,   // [31:0] inst_flicker
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_wdata
);

    logic              r_use_50hz_set;
    logic [DATA_W-1:0] r_base_voltage_recip;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              core_idle;
    logic              core_done;
    logic [DATA_W-1:0] core_result;
    logic              out_free;
    logic              in_accept;

    assign out_free  = !r_out_valid || m_axis_tready;
    assign in_accept = s_axis_tvalid && core_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_50hz_set       <= 1'b0;
            r_base_voltage_recip <= RECIP_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_USE_50HZ:   r_use_50hz_set <= i_cfg_wdata[0];
                REG_BASE_RECIP: r_base_voltage_recip <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (core_done && out_free) begin
                r_out_valid <= 1'b1;
                r_out_data  <= core_result;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    flk_core #(
        .SAMPLES_PER_SECOND (SAMPLES_PER_SECOND),
        .SAMPLE_WIDTH       (SAMPLE_WIDTH)
    ) u_core (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_start              (in_accept),
        .i_sample             (s_axis_tdata),
        .i_restart            (s_axis_tuser),
        .i_use_50hz_set       (r_use_50hz_set),
        .i_base_voltage_recip (r_base_voltage_recip),
        .i_out_free           (out_free),
        .o_idle               (core_idle),
        .o_done               (core_done),
        .o_result             (core_result)
    );

    assign s_axis_tready = core_idle;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== sim/testbench.sv =====
// Testbench for the flicker filter chain: directed and random samples, checked by a scoreboard.
module testbench;
    import flk_pkg::*;

    localparam longint CYCLE_LIMIT = 6000000;

    class flicker_scoreboard;
        bit              set50;
        bit [31:0]       recip;
        int              hp_in, hp_out, lp_in, lp_out;
        int              bp_in[2], bp_out[2], wt_in[2], wt_out[2];
        int unsigned     warm;
        bit [31:0]       expected_flicker[$];
        int              mismatches;
        int              orphans;

        function new();
            set50 = 0;
            recip = RECIP_RESET;
            clear();
        endfunction

        function void clear();
            hp_in = 0; hp_out = 0; lp_in = 0; lp_out = 0;
            bp_in = '{0, 0}; bp_out = '{0, 0}; wt_in = '{0, 0}; wt_out = '{0, 0};
            warm = 0;
        endfunction

        function void write_reg(t_reg_idx idx, bit [31:0] val);
            if (idx == REG_USE_50HZ) set50 = val[0];
            else recip = val;
        endfunction

        function int clip(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'sh8000_0000;
            return int'(v);
        endfunction

        function int ratio_q30(longint num, longint unsigned den);
            longint unsigned m, q, r;
            bit neg;
            if (den == 0) return 0;
            neg = num < 0;
            m = neg ? longint'(-num) : longint'(num);
            q = m / den;
            r = m % den;
            if (q >= 2) return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            for (int i = 0; i < 31; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= den) begin
                    r = r - den;
                    q = q | 1;
                end
            end
            q = (q + 1) >> 1;
            return clip(neg ? -longint'(q) : longint'(q));
        endfunction

        function longint coef_mul(int c, int x);
            longint p;
            longint unsigned m;
            p = longint'(c) * longint'(x);
            m = (p < 0) ? longint'(-p) : longint'(p);
            m = (m + (64'd1 << 29)) >> 30;
            return (p < 0) ? -longint'(m) : longint'(m);
        endfunction

        function longint ang(longint unsigned fmicro);
            longint unsigned dv;
            dv = 64'd1000000 << (30 - 11);
            return longint'((2 * 64'd3373259426 * fmicro + dv / 2) / dv);
        endfunction

        function void note_sample(bit [15:0] smp, bit rs);
            longint fs, fss, kn, kd, w1, lam, w2, w3, w4, q4, a0, pr, sm, d0;
            longint unsigned v, pi30;
            int hg, ha, lg, la, b0, a1, a2, c0, c1, c2, e1, e2;
            int x, hp, bp, wt, sq, lp;
            pi30 = 64'd3373259426;
            fs = 120;
            fss = fs << 11;
            if (set50) begin
                kn = 174802; kd = 100000;
                lam = ang(4059810); w1 = ang(9154940);
                w2 = ang(2279790); w3 = ang(1225350); w4 = ang(21900000);
            end else begin
                kn = 16357; kd = 7830;
                lam = ang(4167375); w1 = ang(9077169);
                w2 = ang(2939902); w3 = ang(1394468); w4 = ang(17315120);
            end
            v = longint'(20 * fs) << 30;
            hg = ratio_q30(longint'(v), v + pi30);
            ha = ratio_q30(longint'(pi30) - longint'(v), v + pi30);
            lg = ratio_q30(5, 5 + 3 * fs);
            la = ratio_q30(5 - 3 * fs, 5 + 3 * fs);
            q4 = 4 * fss * fss;
            a0 = w1 * w1 + 4 * lam * fss + q4;
            b0 = ratio_q30(2 * kn * w1 * fss, kd * a0);
            a1 = ratio_q30(2 * w1 * w1 - 8 * fss * fss, a0);
            a2 = ratio_q30(w1 * w1 - 4 * lam * fss + q4, a0);
            pr = w3 * w4;
            sm = w3 + w4;
            d0 = pr + 2 * fss * sm + q4;
            c0 = ratio_q30(pr * (w2 + 2 * fss), w2 * d0);
            c1 = ratio_q30(pr * 2 * w2, w2 * d0);
            c2 = ratio_q30(pr * (w2 - 2 * fss), w2 * d0);
            e1 = ratio_q30(2 * pr - 8 * fss * fss, d0);
            e2 = ratio_q30(pr - 2 * fss * sm + q4, d0);

            if (rs) clear();
            v = (longint'(smp) * longint'(recip) + 32) >> 6;
            x = (v > 64'd2147483647) ? 32'sh7FFF_FFFF : int'(v);

            hp = (warm == 0) ? 0 :
                clip(coef_mul(hg, x) - coef_mul(hg, hp_in) - coef_mul(ha, hp_out));
            hp_in = x; hp_out = hp;

            bp = (warm < 2) ? 0 :
                clip(coef_mul(b0, hp) - coef_mul(b0, bp_in[1])
                     - coef_mul(a1, bp_out[0]) - coef_mul(a2, bp_out[1]));
            bp_in[1] = bp_in[0]; bp_in[0] = hp;
            bp_out[1] = bp_out[0]; bp_out[0] = bp;

            wt = (warm < 2) ? 0 :
                clip(coef_mul(c0, bp) + coef_mul(c1, wt_in[0]) + coef_mul(c2, wt_in[1])
                     - coef_mul(e1, wt_out[0]) - coef_mul(e2, wt_out[1]));
            wt_in[1] = wt_in[0]; wt_in[0] = bp;
            wt_out[1] = wt_out[0]; wt_out[0] = wt;

            v = (longint'(wt) * longint'(wt) + (64'd1 << 23)) >> 24;
            sq = (v > 64'd2147483647) ? 32'sh7FFF_FFFF : int'(v);

            lp = (warm == 0) ? 0 :
                clip(coef_mul(lg, sq) + coef_mul(lg, lp_in) - coef_mul(la, lp_out));
            lp_in = sq; lp_out = lp;

            if (warm < 2) warm++;

            if (lp <= 0) begin
                v = 0;
            end else begin
                v = (longint'(lp) * 64'd1000000000 + 64'd164480) / 64'd328960;
                if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
            end
            expected_flicker.push_back(v[31:0]);
        endfunction

        function void check_flicker(bit [31:0] got);
            bit [31:0] want;
            if (expected_flicker.size() == 0) begin
                orphans++;
                if (mismatches + orphans <= 10)
                    $display("unexpected flicker word %h", got);
                return;
            end
            want = expected_flicker.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches + orphans <= 10)
                    $display("flicker mismatch: expected %h, got %h", want, got);
            end
        endfunction
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 s_axis_tvalid = 0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;
    logic                 s_axis_tuser = 0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 0;
    logic [DATA_W-1:0]    m_axis_tdata;
    logic                 i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [DATA_W-1:0]    i_cfg_wdata = '0;

    flicker_scoreboard sb = new();
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_request = 0;
    int          hold_left = 0;
    longint      cycles = 0;
    int unsigned base_level = 100;

    rms_flickermeter_filter_chain_top u_top (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 0;
            hold_left <= hold_left - 1;
        end else if (hold_request > 0) begin
            m_axis_tready <= 0;
            hold_left <= hold_request;
            hold_request <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready) sb.check_flicker(m_axis_tdata);
        end
    end

    task automatic send_word(input bit [15:0] smp, input bit rs);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= rs;
        do begin
            @(negedge i_clk);
            taken = s_axis_tvalid && s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic write_reg(input t_reg_idx idx, input bit [31:0] val);
        i_cfg_we    <= 1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (sb.expected_flicker.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random(input int count, input bit pause_midway);
        int unsigned amp, smp;
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) drain();
            if ($urandom_range(99) < 10) begin
                smp = $urandom_range(16'hFFFF);
            end else begin
                amp = base_level / 10 + 1;
                smp = base_level + $urandom_range(2 * amp) - amp;
                if (smp > 16'hFFFF) smp = 16'hFFFF;
            end
            send_word(smp[15:0], $urandom_range(99) < 2);
        end
    endtask

    task automatic start_phase(input int s_idle, input int r_stall, input bit use50,
                               input bit [31:0] recip);
        drain();
        send_idle_pct = s_idle;
        stall_pct = r_stall;
        write_reg(REG_USE_50HZ, {31'b0, use50});
        write_reg(REG_BASE_RECIP, recip);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_word(16'd0, 1);
        send_word(16'hFFFF, 0);
        send_word(16'd0, 0);
        send_word(16'd1, 0);
        send_word(16'h8000, 0);
        send_word(16'h7FFF, 0);
        for (int i = 0; i < 6; i++) send_word(16'd60 + 16'(i * 20), 0);
        send_word(16'hFFFF, 1);
        send_word(16'd0, 0);
        send_word(16'hFFFF, 0);
        send_word(16'h5555, 0);
        send_word(16'hAAAA, 1);
        base_level = 1;
        send_random(380, 0);

        base_level = $urandom_range(200, 60000);
        start_phase(47, 0, 1, 32'h4000_0000 / base_level);
        send_random(380, 1);

        base_level = $urandom_range(200, 60000);
        start_phase(0, 47, 0, 32'h4000_0000 / base_level);
        hold_request = 4000;
        send_random(380, 0);

        start_phase(10, 10, 1, 32'hFFFF_FFFF);
        send_word(16'hFFFF, 1);
        send_word(16'd0, 0);
        send_random(30, 0);
        start_phase(10, 10, 0, 32'd0);
        send_random(20, 0);

        base_level = $urandom_range(200, 60000);
        start_phase(10, 10, 1, 32'h4000_0000 / base_level);
        send_random(380, 0);

        drain();
        repeat (800) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.orphans == 0 && sb.expected_flicker.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
